[src/optimizer_termination_monitor_unit_assert.svh]
// Assertion macros for the checker module.
`ifndef OPTIMIZER_TERMINATION_MONITOR_UNIT_ASSERT_SVH
`define OPTIMIZER_TERMINATION_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OTM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OTM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/otm_pkg.sv]
`timescale 1ns / 1ps

package otm_pkg;

   localparam int PHI_W    = 48;
   localparam int CNT_W    = 16;
   localparam int TOL_W    = 16;
   localparam int RCT_W    = 31;
   localparam int RPC_W    = 32;
   localparam int BCU_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   localparam logic [PHI_W-1:0] PHI_MAX = {PHI_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CNT_W-1:0] MAX_ITER_RST      = 16'd50;
   localparam logic [TOL_W-1:0] PHI_REL_TOL_RST   = 16'd655;
   localparam logic [BCU_W-1:0] BEST_USED_RST     = 4'd4;
   localparam logic [CNT_W-1:0] NO_RED_LIMIT_RST  = 16'd3;
   localparam logic [RCT_W-1:0] REL_CHG_TOL_RST   = 31'd655;
   localparam logic [CNT_W-1:0] SMALL_LIMIT_RST   = 16'd3;
   localparam logic             DYN_REGUL_RST     = 1'b0;
   localparam logic [PHI_W-1:0] ACCEPT_LEVEL_RST  = 48'd0;

   typedef enum logic [2:0] {
      REASON_CONTINUE     = 3'd0,
      REASON_ITER_LIMIT   = 3'd1,
      REASON_PHI_ZERO     = 3'd2,
      REASON_NO_REDUCTION = 3'd3,
      REASON_PHI_SPREAD   = 3'd4,
      REASON_SMALL_CHANGE = 3'd5
   } otm_reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ITERATIONS     = 3'd0,
      CSR_PHI_REL_TOL        = 3'd1,
      CSR_BEST_COUNT_USED    = 3'd2,
      CSR_NO_REDUCTION_LIMIT = 3'd3,
      CSR_REL_CHANGE_TOL     = 3'd4,
      CSR_SMALL_CHANGE_LIMIT = 3'd5,
      CSR_DYNAMIC_REGUL      = 3'd6,
      CSR_MEAS_ACCEPT_LEVEL  = 3'd7
   } otm_csr_type;

   typedef struct packed {
      logic [CNT_W-1:0] max_iterations;
      logic [TOL_W-1:0] phi_rel_tol;
      logic [BCU_W-1:0] best_count_used;
      logic [CNT_W-1:0] no_reduction_limit;
      logic [RCT_W-1:0] rel_change_tol;
      logic [CNT_W-1:0] small_change_limit;
      logic             dynamic_regul;
      logic [PHI_W-1:0] meas_accept_level;
   } otm_cfg_type;

   // Per-request results of the list/counter stage, consumed by the judge stage.
   typedef struct packed {
      logic [PHI_W-1:0] phi;
      logic [CNT_W-1:0] iteration;
      logic             iter_limit;
      logic             no_red_over;
      logic             small_over;
      logic             list_full;
      logic [PHI_W-1:0] spread;
   } otm_mid_type;

endpackage

[src/optimizer_termination_monitor_unit.sv]
`timescale 1ns / 1ps
// A request moves through the input, mid and output registers to rsp_valid.
// One request per cycle unless stalled; list and counters update in one pass.
// The pipeline has three registered stages that close bubbles under rsp_stall.
// Reset (synchronous) clears counters, list fill and acceptance flag, and
// restores all configuration registers to their defaults.

module optimizer_termination_monitor_unit #(
   parameter int BEST_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [otm_pkg::PHI_W-1:0]         req_phi_meas,
   input  logic [otm_pkg::PHI_W-1:0]         req_phi_regul,
   input  logic signed [otm_pkg::RPC_W-1:0]  req_rel_par_change,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_terminate,
   output logic [2:0]                        rsp_stop_reason,
   output logic [otm_pkg::PHI_W-1:0]         rsp_objective_phi,
   output logic [otm_pkg::CNT_W-1:0]         rsp_iteration_number,
   input  logic                              csr_write_en,
   input  logic [otm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [otm_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import otm_pkg::*;

   otm_cfg_type cfg_ff, cfg_in;

   logic              in_v_ff, in_v_in;
   logic [PHI_W-1:0]  pm_ff, pr_ff;
   logic signed [RPC_W-1:0] rc_ff;

   otm_mid_type       mid_comb;
   otm_mid_type       mid_ff;
   logic              mid_v_ff, mid_v_in;

   logic              term_comb;
   otm_reason_type    reason_comb;
   logic              out_v_ff, out_v_in;
   logic              term_ff;
   otm_reason_type    reason_ff;
   logic [PHI_W-1:0]  phi_ff;
   logic [CNT_W-1:0]  iter_ff;

   logic              out_en, mid_en, in_en, step;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (otm_csr_type'(csr_index))
            CSR_MAX_ITERATIONS:     cfg_in.max_iterations     = csr_wdata[CNT_W-1:0];
            CSR_PHI_REL_TOL:        cfg_in.phi_rel_tol        = csr_wdata[TOL_W-1:0];
            CSR_BEST_COUNT_USED:    cfg_in.best_count_used    = csr_wdata[BCU_W-1:0];
            CSR_NO_REDUCTION_LIMIT: cfg_in.no_reduction_limit = csr_wdata[CNT_W-1:0];
            CSR_REL_CHANGE_TOL:     cfg_in.rel_change_tol     = csr_wdata[RCT_W-1:0];
            CSR_SMALL_CHANGE_LIMIT: cfg_in.small_change_limit = csr_wdata[CNT_W-1:0];
            CSR_DYNAMIC_REGUL:      cfg_in.dynamic_regul      = csr_wdata[0];
            CSR_MEAS_ACCEPT_LEVEL:  cfg_in.meas_accept_level  = csr_wdata[PHI_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations     <= MAX_ITER_RST;
         cfg_ff.phi_rel_tol        <= PHI_REL_TOL_RST;
         cfg_ff.best_count_used    <= BEST_USED_RST;
         cfg_ff.no_reduction_limit <= NO_RED_LIMIT_RST;
         cfg_ff.rel_change_tol     <= REL_CHG_TOL_RST;
         cfg_ff.small_change_limit <= SMALL_LIMIT_RST;
         cfg_ff.dynamic_regul      <= DYN_REGUL_RST;
         cfg_ff.meas_accept_level  <= ACCEPT_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      out_en    = !out_v_ff || !rsp_stall;
      mid_en    = !mid_v_ff || out_en;
      in_en     = !in_v_ff || mid_en;
      req_stall = !in_en;
      step      = in_v_ff && mid_en;
      in_v_in   = in_en ? req_valid : in_v_ff;
      mid_v_in  = mid_en ? in_v_ff : mid_v_ff;
      out_v_in  = out_en ? mid_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         mid_v_ff <= mid_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         pm_ff <= req_phi_meas;
         pr_ff <= req_phi_regul;
         rc_ff <= req_rel_par_change;
      end
      if (mid_en) begin
         mid_ff <= mid_comb;
      end
      if (out_en) begin
         term_ff   <= term_comb;
         reason_ff <= reason_comb;
         phi_ff    <= mid_ff.phi;
         iter_ff   <= mid_ff.iteration;
      end
   end

   otm_front #(
      .BEST_DEPTH(BEST_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .cfg            (cfg_ff),
      .phi_meas       (pm_ff),
      .phi_regul      (pr_ff),
      .rel_par_change (rc_ff),
      .mid            (mid_comb)
   );

   otm_judge u_judge (
      .mid         (mid_ff),
      .phi_rel_tol (cfg_ff.phi_rel_tol),
      .terminate   (term_comb),
      .stop_reason (reason_comb)
   );

   assign rsp_valid            = out_v_ff;
   assign rsp_terminate        = term_ff;
   assign rsp_stop_reason      = reason_ff;
   assign rsp_objective_phi    = phi_ff;
   assign rsp_iteration_number = iter_ff;

endmodule

[src/otm_front.sv]
`timescale 1ns / 1ps

module otm_front #(
   parameter int BEST_DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  otm_pkg::otm_cfg_type        cfg,
   input  logic [otm_pkg::PHI_W-1:0]   phi_meas,
   input  logic [otm_pkg::PHI_W-1:0]   phi_regul,
   input  logic signed [otm_pkg::RPC_W-1:0] rel_par_change,
   output otm_pkg::otm_mid_type        mid
);
   import otm_pkg::*;

   localparam int FILL_W = $clog2(BEST_DEPTH + 1);
   localparam int IDX_W  = (BEST_DEPTH > 1) ? $clog2(BEST_DEPTH) : 1;

   logic [PHI_W-1:0]  best_ff [BEST_DEPTH];
   logic [PHI_W-1:0]  best_in [BEST_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  iter_ff, iter_in;
   logic [CNT_W-1:0]  nored_ff, nored_in;
   logic [CNT_W-1:0]  small_ff, small_in;
   logic              accept_ff, accept_in;

   logic [FILL_W-1:0] used;
   logic [FILL_W-1:0] fill_eff;
   logic [FILL_W-1:0] top_idx;
   logic [FILL_W-1:0] new_top_idx;
   logic [FILL_W-1:0] base_len;
   logic [PHI_W:0]    phi_sum;
   logic [PHI_W-1:0]  phi;
   logic [PHI_W-1:0]  top_cur;
   logic [PHI_W-1:0]  prv [BEST_DEPTH];
   logic [BEST_DEPTH-1:0] le;
   logic [BEST_DEPTH-1:0] prv_le;
   logic              reject;
   logic              clear;
   logic              insert;
   logic              write;
   logic [RPC_W-1:0]  rc;
   logic [RPC_W-1:0]  mag;

   always_comb begin
      if (cfg.best_count_used == '0) begin
         used = FILL_W'(1);
      end else if (int'(cfg.best_count_used) > BEST_DEPTH) begin
         used = FILL_W'(BEST_DEPTH);
      end else begin
         used = FILL_W'(cfg.best_count_used);
      end

      iter_in = (iter_ff == CNT_MAX) ? iter_ff : iter_ff + CNT_W'(1);

      phi_sum   = {1'b0, phi_meas} + {1'b0, phi_regul};
      phi       = PHI_MAX;
      reject    = 1'b0;
      clear     = 1'b0;
      accept_in = accept_ff;
      if (!cfg.dynamic_regul) begin
         phi = phi_sum[PHI_W] ? PHI_MAX : phi_sum[PHI_W-1:0];
      end else if (!accept_ff && phi_meas > cfg.meas_accept_level) begin
         phi = phi_meas;
      end else if (!accept_ff) begin
         clear     = 1'b1;
         accept_in = 1'b1;
         phi       = phi_regul;
      end else if (phi_meas < cfg.meas_accept_level) begin
         phi = phi_regul;
      end else begin
         reject = 1'b1;
      end

      fill_eff = clear ? '0 : fill_ff;
      insert   = fill_eff < used;
      top_idx  = fill_eff - FILL_W'(1);
      top_cur  = best_ff[top_idx[IDX_W-1:0]];
      write    = !reject && (insert || phi < top_cur);
      base_len = insert ? fill_eff : top_idx;

      if (reject) begin
         nored_in = nored_ff;
      end else if (fill_eff == '0 || phi <= best_ff[0]) begin
         nored_in = '0;
      end else begin
         nored_in = (nored_ff == CNT_MAX) ? nored_ff : nored_ff + CNT_W'(1);
      end

      // Sorted insert: new value lands after every kept entry that is <= it.
      for (int i = 0; i < BEST_DEPTH; i++) begin
         le[i] = (FILL_W'(i) < base_len) && (best_ff[i] <= phi);
      end
      prv[0]    = phi;
      prv_le[0] = 1'b1;
      for (int i = 1; i < BEST_DEPTH; i++) begin
         prv[i]    = best_ff[i-1];
         prv_le[i] = le[i-1];
      end
      for (int i = 0; i < BEST_DEPTH; i++) begin
         best_in[i] = best_ff[i];
         if (write && FILL_W'(i) <= base_len) begin
            if (le[i]) begin
               best_in[i] = best_ff[i];
            end else if (prv_le[i]) begin
               best_in[i] = phi;
            end else begin
               best_in[i] = prv[i];
            end
         end
      end
      fill_in = (!reject && insert) ? fill_eff + FILL_W'(1) : fill_eff;

      rc  = rel_par_change;
      mag = rc[RPC_W-1] ? (~rc + RPC_W'(1)) : rc;
      if (mag < {1'b0, cfg.rel_change_tol}) begin
         small_in = (small_ff == CNT_MAX) ? small_ff : small_ff + CNT_W'(1);
      end else begin
         small_in = '0;
      end

      new_top_idx     = fill_in - FILL_W'(1);
      mid.phi         = phi;
      mid.iteration   = iter_in;
      mid.iter_limit  = iter_in >= cfg.max_iterations;
      mid.no_red_over = nored_in > cfg.no_reduction_limit;
      mid.small_over  = small_in > cfg.small_change_limit;
      mid.list_full   = fill_in >= used;
      mid.spread      = (fill_in == '0) ? '0
                        : best_in[new_top_idx[IDX_W-1:0]] - best_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         iter_ff   <= '0;
         nored_ff  <= '0;
         small_ff  <= '0;
         accept_ff <= 1'b0;
      end else if (step) begin
         fill_ff   <= fill_in;
         iter_ff   <= iter_in;
         nored_ff  <= nored_in;
         small_ff  <= small_in;
         accept_ff <= accept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         best_ff <= best_in;
      end
   end

endmodule

[src/otm_judge.sv]
`timescale 1ns / 1ps

module otm_judge (
   input  otm_pkg::otm_mid_type         mid,
   input  logic [otm_pkg::TOL_W-1:0]    phi_rel_tol,
   output logic                         terminate,
   output otm_pkg::otm_reason_type      stop_reason
);
   import otm_pkg::*;

   localparam int PROD_W = PHI_W + TOL_W;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] spread_q;
   logic              spread_ok;

   always_comb begin
      prod      = PROD_W'(mid.phi) * PROD_W'(phi_rel_tol);
      spread_q  = {mid.spread, {TOL_W{1'b0}}};
      spread_ok = mid.list_full && (spread_q <= prod);

      if (mid.iter_limit) begin
         stop_reason = REASON_ITER_LIMIT;
      end else if (mid.phi == '0) begin
         stop_reason = REASON_PHI_ZERO;
      end else if (mid.no_red_over) begin
         stop_reason = REASON_NO_REDUCTION;
      end else if (spread_ok) begin
         stop_reason = REASON_PHI_SPREAD;
      end else if (mid.small_over) begin
         stop_reason = REASON_SMALL_CHANGE;
      end else begin
         stop_reason = REASON_CONTINUE;
      end
      terminate = stop_reason != REASON_CONTINUE;
   end

endmodule

[src/otm_checker.sv]
`timescale 1ns / 1ps
`include "optimizer_termination_monitor_unit_assert.svh"

module otm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_terminate,
   input logic [2:0]                        rsp_stop_reason,
   input logic [otm_pkg::PHI_W-1:0]         rsp_objective_phi,
   input logic [otm_pkg::CNT_W-1:0]         rsp_iteration_number
);
   import otm_pkg::*;

   `OTM_ASSERT_IMP(a_term_matches_reason, clock, reset, rsp_valid,
      rsp_terminate == (rsp_stop_reason != REASON_CONTINUE), "terminate and reason disagree")

   `OTM_ASSERT_IMP(a_zero_phi_stops, clock, reset,
      rsp_valid && rsp_objective_phi == '0,
      rsp_stop_reason == REASON_ITER_LIMIT || rsp_stop_reason == REASON_PHI_ZERO,
      "zero phi did not stop")

   `OTM_ASSERT_IMP(a_phi_zero_reason, clock, reset,
      rsp_valid && rsp_stop_reason == REASON_PHI_ZERO,
      rsp_objective_phi == '0, "phi zero reason with nonzero phi")

   `OTM_ASSERT_IMP(a_iter_nonzero, clock, reset, rsp_valid,
      rsp_iteration_number != '0, "response with iteration count zero")

   `OTM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_objective_phi) && $stable(rsp_stop_reason),
      "stalled response changed")

endmodule

bind optimizer_termination_monitor_unit otm_checker u_otm_checker (.*);

[tb/optimizer_termination_monitor_unit_test.sv]
`timescale 1ns / 1ps

module optimizer_termination_monitor_unit_test;
   import otm_pkg::*;

   localparam int BEST_DEPTH = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic             terminate;
      otm_reason_type   reason;
      logic [PHI_W-1:0] phi;
      logic [CNT_W-1:0] iteration;
   } verdict_type;

   class termination_scoreboard;
      otm_cfg_type      cfg;
      logic [PHI_W-1:0] lowest_phis[BEST_DEPTH];
      int unsigned      fill;
      logic [CNT_W-1:0] iter_count;
      logic [CNT_W-1:0] stale_count;
      logic [CNT_W-1:0] small_count;
      bit               accepted;
      verdict_type      verdict_q[$];
      int unsigned      errors;
      int unsigned      responses;

      function new();
         cfg.max_iterations     = MAX_ITER_RST;
         cfg.phi_rel_tol        = PHI_REL_TOL_RST;
         cfg.best_count_used    = BEST_USED_RST;
         cfg.no_reduction_limit = NO_RED_LIMIT_RST;
         cfg.rel_change_tol     = REL_CHG_TOL_RST;
         cfg.small_change_limit = SMALL_LIMIT_RST;
         cfg.dynamic_regul      = DYN_REGUL_RST;
         cfg.meas_accept_level  = ACCEPT_LEVEL_RST;
         foreach (lowest_phis[i]) lowest_phis[i] = '0;
         fill        = 0;
         iter_count  = '0;
         stale_count = '0;
         small_count = '0;
         accepted    = 0;
         errors      = 0;
         responses   = 0;
      endfunction

      function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
         return (c == CNT_MAX) ? c : c + 16'd1;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      task report(string msg);
         if (errors < 40) $display("ERROR: %s", msg);
         errors++;
      endtask

      function void note_request(logic [PHI_W-1:0] pm, logic [PHI_W-1:0] pr,
                                 logic [RPC_W-1:0] rc);
         logic [PHI_W:0]   sum;
         logic [PHI_W-1:0] phi;
         logic [PHI_W-1:0] spread;
         logic [PHI_W-1:0] swap;
         logic [RPC_W:0]   mag;
         logic [63:0]      lhs;
         logic [63:0]      rhs;
         bit               reject;
         int unsigned      used;
         int               pos;
         otm_reason_type   why;
         verdict_type      v;
         used = cfg.best_count_used;
         if (used == 0) used = 1;
         if (used > BEST_DEPTH) used = BEST_DEPTH;
         iter_count = bump(iter_count);
         phi = PHI_MAX;
         reject = 0;
         if (!cfg.dynamic_regul) begin
            sum = {1'b0, pm} + {1'b0, pr};
            phi = sum[PHI_W] ? PHI_MAX : sum[PHI_W-1:0];
         end else if (!accepted && pm > cfg.meas_accept_level) begin
            phi = pm;
         end else if (!accepted) begin
            fill = 0;
            accepted = 1;
            phi = pr;
         end else if (pm < cfg.meas_accept_level) begin
            phi = pr;
         end else begin
            reject = 1;
         end

         if (!reject) begin
            if (fill == 0 || phi <= lowest_phis[0]) stale_count = '0;
            else stale_count = bump(stale_count);
            pos = 0;
            if (fill < used) begin
               lowest_phis[fill] = phi;
               fill++;
               pos = fill - 1;
            end else if (phi < lowest_phis[fill-1]) begin
               lowest_phis[fill-1] = phi;
               pos = fill - 1;
            end
            while (pos > 0 && lowest_phis[pos-1] > lowest_phis[pos]) begin
               swap = lowest_phis[pos-1];
               lowest_phis[pos-1] = lowest_phis[pos];
               lowest_phis[pos] = swap;
               pos--;
            end
         end

         mag = rc[RPC_W-1] ? {1'b0, (~rc + 32'd1)} : {1'b0, rc};
         if (mag < {2'b00, cfg.rel_change_tol}) small_count = bump(small_count);
         else small_count = '0;

         why = REASON_CONTINUE;
         if (iter_count >= cfg.max_iterations) begin
            why = REASON_ITER_LIMIT;
         end else begin
            spread = (fill > 0) ? lowest_phis[fill-1] - lowest_phis[0] : '0;
            lhs = {spread, 16'h0000};
            rhs = {48'd0, cfg.phi_rel_tol} * {16'd0, phi};
            if (phi == '0) why = REASON_PHI_ZERO;
            else if (stale_count > cfg.no_reduction_limit) why = REASON_NO_REDUCTION;
            else if (fill >= used && lhs <= rhs) why = REASON_PHI_SPREAD;
            else if (small_count > cfg.small_change_limit) why = REASON_SMALL_CHANGE;
         end
         v.terminate = (why != REASON_CONTINUE);
         v.reason    = why;
         v.phi       = phi;
         v.iteration = iter_count;
         verdict_q = {verdict_q, v};
      endfunction

      task check_response(logic term, logic [2:0] reason, logic [PHI_W-1:0] phi,
                          logic [CNT_W-1:0] iter);
         verdict_type v;
         responses++;
         if (verdict_q.size() == 0) begin
            report($sformatf("response %0d with no request: phi=%h iter=%0d",
                             responses, phi, iter));
            return;
         end
         v = verdict_q.pop_front();
         if (term !== v.terminate || reason !== v.reason || phi !== v.phi ||
             iter !== v.iteration)
            report($sformatf("response %0d: got %b/%0d/%h/%0d want %b/%0d/%h/%0d",
                             responses, term, reason, phi, iter,
                             v.terminate, v.reason, v.phi, v.iteration));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [PHI_W-1:0]        req_phi_meas;
   logic [PHI_W-1:0]        req_phi_regul;
   logic signed [RPC_W-1:0] req_rel_par_change;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_terminate;
   logic [2:0]              rsp_stop_reason;
   logic [PHI_W-1:0]        rsp_objective_phi;
   logic [CNT_W-1:0]        rsp_iteration_number;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DAT_W-1:0]    csr_wdata;

   termination_scoreboard sb;
   int unsigned burst_left;
   int unsigned stall_window;
   int unsigned stall_mode;
   int unsigned idle_cycles;

   optimizer_termination_monitor_unit #(.BEST_DEPTH(BEST_DEPTH)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_phi_meas         (req_phi_meas),
      .req_phi_regul        (req_phi_regul),
      .req_rel_par_change   (req_rel_par_change),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_terminate        (rsp_terminate),
      .rsp_stop_reason      (rsp_stop_reason),
      .rsp_objective_phi    (rsp_objective_phi),
      .rsp_iteration_number (rsp_iteration_number),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_window = 0;
      end else begin
         if (stall_window == 0) begin
            stall_window = $urandom_range(20, 120);
            stall_mode = $urandom_range(0, 3);
         end
         stall_window--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= ((stall_window % 8) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_terminate, rsp_stop_reason, rsp_objective_phi,
                           rsp_iteration_number);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("optimizer_termination_monitor_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [PHI_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[PHI_W-1:0];
   endfunction

   function automatic logic [RPC_W-1:0] pick_change();
      logic [31:0] span;
      logic [31:0] mag;
      span = (sb.cfg.rel_change_tol > 31'h3FFF_FFFF) ? 32'h7FFF_FFFF
                                                      : {sb.cfg.rel_change_tol, 1'b0};
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            mag = $urandom_range(span, 0);
            return ($urandom_range(0, 1) == 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CNT_MAX;
         default: return 16'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic otm_cfg_type random_config();
      otm_cfg_type c;
      case ($urandom_range(0, 9))
         0: c.max_iterations = '0;
         1: c.max_iterations = 16'd1;
         2, 3: c.max_iterations = sb.iter_count + 16'($urandom_range(1, 80));
         default: c.max_iterations = CNT_MAX;
      endcase
      case ($urandom_range(0, 4))
         0: c.phi_rel_tol = '0;
         1: c.phi_rel_tol = 16'hFFFF;
         2: c.phi_rel_tol = 16'($urandom());
         default: c.phi_rel_tol = 16'($urandom_range(1, 2000));
      endcase
      if ($urandom_range(0, 3) == 0) c.best_count_used = 4'($urandom_range(0, 15));
      else c.best_count_used = 4'($urandom_range(1, BEST_DEPTH));
      c.no_reduction_limit = pick_limit();
      case ($urandom_range(0, 5))
         0: c.rel_change_tol = '0;
         1: c.rel_change_tol = 31'h7FFF_FFFF;
         2: c.rel_change_tol = 31'd65536;
         3: c.rel_change_tol = 31'($urandom());
         default: c.rel_change_tol = 31'($urandom_range(1, 4096));
      endcase
      c.small_change_limit = pick_limit();
      c.dynamic_regul = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: c.meas_accept_level = '0;
         1: c.meas_accept_level = PHI_MAX;
         2: c.meas_accept_level = rand48();
         default: c.meas_accept_level = rand48() >> $urandom_range(4, 20);
      endcase
      return c;
   endfunction

   task automatic send_item(input logic [PHI_W-1:0] pm, input logic [PHI_W-1:0] pr,
                            input logic [RPC_W-1:0] rc);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 30);
      end
      req_valid          <= 1'b1;
      req_phi_meas       <= pm;
      req_phi_regul      <= pr;
      req_rel_par_change <= rc;
      do @(posedge clock); while (req_stall);
      sb.note_request(pm, pr, rc);
      burst_left--;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input otm_csr_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic apply_config(input otm_cfg_type c);
      csr_put(CSR_MAX_ITERATIONS, CSR_DAT_W'(c.max_iterations));
      csr_put(CSR_PHI_REL_TOL, CSR_DAT_W'(c.phi_rel_tol));
      csr_put(CSR_BEST_COUNT_USED, CSR_DAT_W'(c.best_count_used));
      csr_put(CSR_NO_REDUCTION_LIMIT, CSR_DAT_W'(c.no_reduction_limit));
      csr_put(CSR_REL_CHANGE_TOL, CSR_DAT_W'(c.rel_change_tol));
      csr_put(CSR_SMALL_CHANGE_LIMIT, CSR_DAT_W'(c.small_change_limit));
      csr_put(CSR_DYNAMIC_REGUL, CSR_DAT_W'(c.dynamic_regul));
      csr_put(CSR_MEAS_ACCEPT_LEVEL, c.meas_accept_level);
      csr_write_en <= 1'b0;
      @(posedge clock);
      sb.cfg = c;
   endtask

   task automatic random_phase(input int unsigned count, input bit with_pause);
      logic [PHI_W-1:0] base;
      logic [PHI_W-1:0] target;
      logic [PHI_W-1:0] pm;
      logic [PHI_W-1:0] pr;
      logic [PHI_W-1:0] level;
      int unsigned      kind;
      base = rand48() >> $urandom_range(8, 28);
      level = sb.cfg.meas_accept_level;
      for (int unsigned n = 0; n < count; n++) begin
         if (with_pause && n == count / 2) drain_and_settle();
         if ($urandom_range(0, 7) == 0) base = base - (base >> 5);
         kind = $urandom_range(0, 9);
         case (kind)
            0: target = rand48();
            1: target = 48'($urandom_range(0, 3));
            2: target = PHI_MAX - 48'($urandom_range(0, 3));
            default: target = base + (rand48() >> $urandom_range(12, 47));
         endcase
         if (sb.cfg.dynamic_regul) begin
            pr = target;
            case ($urandom_range(0, 5))
               0: pm = level;
               1: pm = level - 48'd1;
               2: pm = level + 48'd1;
               3: pm = rand48();
               default: pm = level >> $urandom_range(1, 8);
            endcase
         end else if (kind == 0) begin
            pm = rand48();
            pr = rand48();
         end else begin
            pr = target >> $urandom_range(1, 48);
            pm = target - pr;
         end
         send_item(pm, pr, pick_change());
      end
      drain_and_settle();
   endtask

   initial begin
      otm_cfg_type c;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_phi_meas       = '0;
      req_phi_regul      = '0;
      req_rel_par_change = '0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_MAX_ITERATIONS;
      csr_wdata          = '0;
      burst_left         = 0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, static sum: zero phi, saturation, change magnitude edges, spread
      send_item('0, '0, 32'h0000_0000);
      send_item(PHI_MAX, PHI_MAX, 32'h7FFF_FFFF);
      send_item(PHI_MAX, '0, 32'h8000_0000);
      send_item(48'd100 << 16, '0, 32'hFFFF_FFFF);
      send_item((48'd100 << 16) + 48'd32768, '0, 32'd655);
      send_item((48'd100 << 16) + 48'd13107, '0, 32'd654);
      send_item(48'd99 << 16, 48'd1 << 16, -32'sd655);
      send_item(48'd101 << 16, '0, -32'sd654);
      send_item(48'd102 << 16, '0, 32'd0);
      send_item(48'd103 << 16, '0, 32'd0);
      send_item(48'd104 << 16, '0, 32'd0);
      send_item(48'd105 << 16, '0, 32'd1);
      drain_and_settle();

      // all minimum: iteration limit zero, kept count zero acts as one
      c.max_iterations     = '0;
      c.phi_rel_tol        = '0;
      c.best_count_used    = '0;
      c.no_reduction_limit = '0;
      c.rel_change_tol     = '0;
      c.small_change_limit = '0;
      c.dynamic_regul      = 1'b0;
      c.meas_accept_level  = '0;
      apply_config(c);
      send_item(48'd7, 48'd9, 32'd0);
      send_item(48'd3, 48'd2, 32'h8000_0000);
      drain_and_settle();

      // all maximum: kept count above depth
      c.max_iterations     = CNT_MAX;
      c.phi_rel_tol        = 16'hFFFF;
      c.best_count_used    = 4'hF;
      c.no_reduction_limit = CNT_MAX;
      c.rel_change_tol     = 31'h7FFF_FFFF;
      c.small_change_limit = CNT_MAX;
      c.dynamic_regul      = 1'b0;
      c.meas_accept_level  = PHI_MAX;
      apply_config(c);
      send_item(48'd500 << 16, '0, 32'h7FFF_FFFE);
      send_item(48'd400 << 16, '0, 32'h8000_0000);
      send_item(48'd600 << 16, '0, 32'h8000_0001);
      drain_and_settle();

      // dynamic: before acceptance, acceptance at the level, then accept/reject
      c.max_iterations     = CNT_MAX;
      c.phi_rel_tol        = PHI_REL_TOL_RST;
      c.best_count_used    = BEST_USED_RST;
      c.no_reduction_limit = NO_RED_LIMIT_RST;
      c.rel_change_tol     = REL_CHG_TOL_RST;
      c.small_change_limit = SMALL_LIMIT_RST;
      c.dynamic_regul      = 1'b1;
      c.meas_accept_level  = 48'd50 << 16;
      apply_config(c);
      send_item(48'd60 << 16, 48'd1, 32'd1000);
      send_item((48'd50 << 16) + 48'd1, 48'd2, 32'd1000);
      send_item(48'd50 << 16, 48'd30 << 16, 32'd1000);
      send_item((48'd50 << 16) - 48'd1, 48'd29 << 16, 32'd1000);
      send_item(48'd50 << 16, 48'd1, 32'd1000);
      send_item(PHI_MAX, 48'd1, 32'd1000);
      send_item('0, '0, 32'd1000);
      drain_and_settle();

      for (int p = 0; p < 12; p++) begin
         apply_config(random_config());
         random_phase(120, p == 5);
      end

      drain_and_settle();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("optimizer_termination_monitor_unit verification clean");
      else
         $display("optimizer_termination_monitor_unit verification failed");
      $finish;
   end

endmodule
